// ===== design/masked_running_statistics_defines.svh =====
// Assertion macros shared by the design files.
`ifndef MASKED_RUNNING_STATISTICS_DEFINES_SVH
`define MASKED_RUNNING_STATISTICS_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define MRS_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Assert that an implication holds in the next cycle, outside reset.
`define MRS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

// ===== design/mrs_pkg.sv =====
`timescale 1ns / 1ps
package mrs_pkg;

  localparam int SampleBitsDefault = 24;
  localparam int CountBitsDefault  = 16;
  localparam int OutBits           = 24;
  localparam int SumBits           = 40;
  localparam int SqBits            = 64;
  localparam int CntOutBits        = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_GOOD  = 2'd1,
    ST_PRIOR    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Snapshot of one finished set, handed from the front to the back.
  typedef struct packed {
    logic signed [OutBits-1:0] max_v;
    logic signed [OutBits-1:0] min_v;
    logic signed [SumBits-1:0] sum;
    logic [SqBits-1:0]         sumsq;
    logic [CntOutBits-1:0]     count;
    status_t                   status;
  } set_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MEAN_SQ,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage

// ===== design/mrs_front.sv =====
`timescale 1ns / 1ps
module mrs_front #(
  parameter int SAMPLE_BITS = mrs_pkg::SampleBitsDefault,
  parameter int COUNT_BITS  = mrs_pkg::CountBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [23:0]         sample,
  input  logic                sample_bad,
  input  logic                prior_error,
  input  logic                last,
  output logic                set_valid,
  output mrs_pkg::set_t       set_data
);

  localparam logic signed [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CMax = {COUNT_BITS{1'b1}};

  logic signed [SAMPLE_BITS-1:0] running_max, running_min, s;
  logic signed [mrs_pkg::SumBits-1:0] running_sum;
  logic [mrs_pkg::SqBits-1:0] running_sum_squares;
  logic [COUNT_BITS-1:0] good_total;
  logic error_seen, overflow_seen;

  logic signed [SAMPLE_BITS-1:0] max_next, min_next;
  logic signed [mrs_pkg::SumBits-1:0] sum_next;
  logic [mrs_pkg::SqBits-1:0] sq_next;
  logic [COUNT_BITS-1:0] cnt_next;
  logic err_next, ovf_next, acc;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  assign s    = sample[SAMPLE_BITS-1:0];
  assign prod = s * s;
  assign acc  = !sample_bad && good_total != CMax;

  always_comb begin
    max_next = running_max;
    min_next = running_min;
    sum_next = running_sum;
    sq_next  = running_sum_squares;
    cnt_next = good_total;
    err_next = error_seen | prior_error;
    ovf_next = overflow_seen | (!sample_bad && good_total == CMax);
    if (acc) begin
      if (s > running_max) max_next = s;
      if (s < running_min) min_next = s;
      sum_next = running_sum + mrs_pkg::SumBits'(s);
      sq_next  = running_sum_squares + mrs_pkg::SqBits'(unsigned'(prod));
      cnt_next = good_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max         <= SMin;
      running_min         <= SMax;
      running_sum         <= '0;
      running_sum_squares <= '0;
      good_total          <= '0;
      error_seen          <= 1'b0;
      overflow_seen       <= 1'b0;
      set_valid           <= 1'b0;
    end else begin
      set_valid <= take && last;
      if (take) begin
        if (last) begin
          // Snapshot the set and clear for the next one.
          set_data.max_v <= mrs_pkg::OutBits'(max_next);
          set_data.min_v <= mrs_pkg::OutBits'(min_next);
          set_data.sum   <= sum_next;
          set_data.sumsq <= sq_next;
          set_data.count <= mrs_pkg::CntOutBits'(cnt_next);
          priority if (err_next) set_data.status <= mrs_pkg::ST_PRIOR;
          else if (ovf_next) set_data.status <= mrs_pkg::ST_OVERFLOW;
          else if (cnt_next == '0) set_data.status <= mrs_pkg::ST_NO_GOOD;
          else set_data.status <= mrs_pkg::ST_OK;
          running_max         <= SMin;
          running_min         <= SMax;
          running_sum         <= '0;
          running_sum_squares <= '0;
          good_total          <= '0;
          error_seen          <= 1'b0;
          overflow_seen       <= 1'b0;
        end else begin
          running_max         <= max_next;
          running_min         <= min_next;
          running_sum         <= sum_next;
          running_sum_squares <= sq_next;
          good_total          <= cnt_next;
          error_seen          <= err_next;
          overflow_seen       <= ovf_next;
        end
      end
    end
  end

endmodule

// ===== design/mrs_back.sv =====
`timescale 1ns / 1ps
`include "masked_running_statistics_defines.svh"
module mrs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mrs_pkg::set_t       set_data,
  input  logic                hold,
  output logic                busy,
  output logic                done,
  output logic [23:0]         max_value,
  output logic [23:0]         min_value,
  output logic [23:0]         mean_value,
  output logic [23:0]         rms_value,
  output logic [23:0]         sigma_value,
  output logic [15:0]         good_count,
  output logic [1:0]          result_status
);

  mrs_pkg::back_state_t state, state_next;
  mrs_pkg::set_t job;

  // Two restoring dividers: each quotient builds one bit a cycle.
  logic [63:0] rem1, q1;   // sumsq / count
  logic [39:0] rem0, q0;   // |sum| / count
  logic [6:0]  cnt;
  logic [64:0] t1;
  logic [40:0] t0;
  logic signed [39:0] mean_s;
  logic [47:0] m2;
  logic [63:0] ms, var_v;
  // Two square-root units, one digit per cycle.
  logic [63:0] sv0, sb0, sr0, sv1, sb1, sr1;
  logic [5:0]  scnt;

  assign t1 = {rem1, q1[63]} - {49'd0, job.count};
  assign t0 = {rem0, q0[39]} - {25'd0, job.count};
  // var uses the product registered last cycle
  assign var_v = (ms > 64'(m2)) ? ms - 64'(m2) : 64'd0;
  assign busy = state != mrs_pkg::BK_IDLE;
  assign done = state == mrs_pkg::BK_DONE;

  always_comb begin
    state_next = state;
    unique case (state)
      mrs_pkg::BK_IDLE:    if (start) state_next = (set_data.status == mrs_pkg::ST_OK)
                                         ? mrs_pkg::BK_DIV : mrs_pkg::BK_DONE;
      mrs_pkg::BK_DIV:     if (cnt == 7'd63) state_next = mrs_pkg::BK_MEAN_SQ;
      mrs_pkg::BK_MEAN_SQ: state_next = mrs_pkg::BK_SQRT;
      mrs_pkg::BK_SQRT:    if (scnt == 6'd31) state_next = mrs_pkg::BK_DONE;
      mrs_pkg::BK_DONE:    if (!hold) state_next = mrs_pkg::BK_IDLE;
      default:             state_next = mrs_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mrs_pkg::BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mrs_pkg::BK_IDLE: begin
        job  <= set_data;
        cnt  <= '0;
        scnt <= '0;
        rem1 <= '0;
        rem0 <= '0;
        q1   <= set_data.sumsq;
        q0   <= set_data.sum[39] ? 40'(-set_data.sum) : 40'(set_data.sum);
      end
      mrs_pkg::BK_DIV: begin
        cnt <= cnt + 7'd1;
        if (!t1[64]) begin
          rem1 <= t1[63:0];
          q1   <= {q1[62:0], 1'b1};
        end else begin
          rem1 <= {rem1[62:0], q1[63]};
          q1   <= {q1[62:0], 1'b0};
        end
        // 40-bit divide runs its last 40 steps.
        if (cnt >= 7'd24) begin
          if (!t0[40]) begin
            rem0 <= t0[39:0];
            q0   <= {q0[38:0], 1'b1};
          end else begin
            rem0 <= {rem0[38:0], q0[39]};
            q0   <= {q0[38:0], 1'b0};
          end
        end
      end
      mrs_pkg::BK_MEAN_SQ: begin
        mean_s <= job.sum[39] ? 40'(-q0) : 40'(q0);
        m2     <= q0[23:0] * q0[23:0];
        ms     <= q1;
        sv0 <= q1; sr0 <= '0; sb0 <= 64'h4000_0000_0000_0000;
      end
      mrs_pkg::BK_SQRT: begin
        scnt <= scnt + 6'd1;
        if (scnt == 6'd0) begin
          sv1 <= var_v; sr1 <= '0; sb1 <= 64'h4000_0000_0000_0000;
        end else begin
          if (sv1 >= sr1 + sb1) begin
            sv1 <= sv1 - (sr1 + sb1);
            sr1 <= (sr1 >> 1) + sb1;
          end else sr1 <= sr1 >> 1;
          sb1 <= sb1 >> 2;
        end
        if (sv0 >= sr0 + sb0) begin
          sv0 <= sv0 - (sr0 + sb0);
          sr0 <= (sr0 >> 1) + sb0;
        end else sr0 <= sr0 >> 1;
        sb0 <= sb0 >> 2;
      end
      default: ;
    endcase
  end

  // The sigma root loads var in its first root step; finish its last step at output.
  logic [63:0] sr1_fin;
  always_comb begin
    if (sv1 >= sr1 + sb1) sr1_fin = (sr1 >> 1) + sb1;
    else sr1_fin = sr1 >> 1;
  end

  logic ok;
  assign ok = job.status == mrs_pkg::ST_OK;
  assign max_value     = ok ? job.max_v : '0;
  assign min_value     = ok ? job.min_v : '0;
  assign mean_value    = ok ? mean_s[23:0] : '0;
  assign rms_value     = ok ? sr0[23:0] : '0;
  assign sigma_value   = ok ? sr1_fin[23:0] : '0;
  assign good_count    = job.count;
  assign result_status = job.status;

  `MRS_ASSERT_IMP(a_start_idle, clk, rst, start, state == mrs_pkg::BK_IDLE)
  `MRS_ASSERT_NEXT(a_done_idle, clk, rst, done && !hold, state == mrs_pkg::BK_IDLE)
  `MRS_ASSERT_IMP(a_nogood_zero, clk, rst,
    done && job.status == mrs_pkg::ST_NO_GOOD, job.count == '0)

endmodule

// ===== design/mrs_queue.sv =====
`timescale 1ns / 1ps
`include "masked_running_statistics_defines.svh"
module mrs_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic         full,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr && !full) wp <= ~wp;
      if (rd && !empty) rp <= ~rp;
      cnt <= cnt + 2'(wr && !full) - 2'(rd && !empty);
    end
  end

  `MRS_ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, cnt != 2'd3)
  `MRS_ASSERT_NEXT(a_fill, clk, rst, empty && wr, !empty)

endmodule

// ===== design/masked_running_statistics.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake        | Fields
// input    | push / full      | sample, sample_bad, prior_error, last
// result   | pop / empty      | max/min/mean/rms/sigma_value, good_count, result_status
// Samples are taken one per cycle while full is low; accumulation is a registered update.
// A set marked last is snapshotted into a register, then written into a two-entry queue.
// The back end runs a valid set as start, 64 divider steps, mean square, 32 root steps
// and write-out; an invalid set goes from start straight to write-out.
// full rises when the set queue holds two sets, or one with another arriving;
// the back end holds its result while the two-entry result queue is full.
// rst is synchronous and clears accumulators, queues and the back-end FSM.
module masked_running_statistics #(
  parameter int SAMPLE_BITS = mrs_pkg::SampleBitsDefault,
  parameter int COUNT_BITS  = mrs_pkg::CountBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [23:0] sample,
  input  logic        sample_bad,
  input  logic        prior_error,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [23:0] max_value,
  output logic [23:0] min_value,
  output logic [23:0] mean_value,
  output logic [23:0] rms_value,
  output logic [23:0] sigma_value,
  output logic [15:0] good_count,
  output logic [1:0]  result_status
);

  localparam int RW = 5 * 24 + 16 + 2;

  logic set_valid, take, q_full, q_empty, b_busy, b_done, o_full;
  mrs_pkg::set_t set_data, q_data;
  logic [23:0] b_max, b_min, b_mean, b_rms, b_sigma;
  logic [15:0] b_cnt;
  logic [1:0] b_st;
  logic [RW-1:0] o_data;

  // Hold input while the set queue might overflow.
  assign full = q_full;
  assign take = push && !full;

  mrs_front #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst, .take, .sample, .sample_bad, .prior_error, .last,
    .set_valid, .set_data
  );

  // Full also rises while a set arrives at a non-empty queue, so a set in flight always fits.
  logic q_full_raw;
  mrs_queue #(.W($bits(mrs_pkg::set_t))) u_setq (
    .clk, .rst, .wr(set_valid), .wdata(set_data),
    .rd(!b_busy && !q_empty), .full(q_full_raw), .empty(q_empty), .rdata(q_data)
  );
  assign q_full = q_full_raw || (set_valid && !q_empty);

  // Hold the finished result in the back end while the result queue is full.
  mrs_back u_back (
    .clk, .rst, .start(!b_busy && !q_empty), .set_data(q_data), .hold(o_full),
    .busy(b_busy), .done(b_done),
    .max_value(b_max), .min_value(b_min), .mean_value(b_mean),
    .rms_value(b_rms), .sigma_value(b_sigma), .good_count(b_cnt), .result_status(b_st)
  );

  // Result queue; a held result is written once a slot frees up.
  mrs_queue #(.W(RW)) u_resq (
    .clk, .rst, .wr(b_done), .wdata({b_max, b_min, b_mean, b_rms, b_sigma, b_cnt, b_st}),
    .rd(pop), .full(o_full), .empty, .rdata(o_data)
  );

  assign {max_value, min_value, mean_value, rms_value, sigma_value,
          good_count, result_status} = o_data;

endmodule
